>>> hdl/crd_pkg.sv
// ----------------------------------------------------------------------------
// crd_pkg
// Shared types, sizes and lookup tables for the character reference decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package crd_pkg;

  // Longest digit string in a numeric reference
  localparam int MaxDigits  = 8;
  // Held bytes: '&', '#', 'x' and the digits
  localparam int StoreDepth = MaxDigits + 3;
  // Worst run for one input: full replay plus the byte handled again
  localparam int MaxResults = StoreDepth + 1;

  localparam int RcW    = $clog2(StoreDepth + 1);
  localparam int AddrW  = $clog2(StoreDepth);
  localparam int DcW    = $clog2(MaxDigits + 1);
  localparam int CountW = $clog2(MaxResults + 1);

  // Character codes
  localparam logic [7:0] ChAmp   = 8'h26;  // '&'
  localparam logic [7:0] ChHash  = 8'h23;  // '#'
  localparam logic [7:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [7:0] ChApos  = 8'h27;  // '\''
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChQuot  = 8'h22;  // '"'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [7:0] ChLowG  = 8'h67;  // 'g'
  localparam logic [7:0] ChLowL  = 8'h6C;  // 'l'
  localparam logic [7:0] ChLowM  = 8'h6D;  // 'm'
  localparam logic [7:0] ChLowO  = 8'h6F;  // 'o'
  localparam logic [7:0] ChLowP  = 8'h70;  // 'p'
  localparam logic [7:0] ChLowQ  = 8'h71;  // 'q'
  localparam logic [7:0] ChLowS  = 8'h73;  // 's'
  localparam logic [7:0] ChLowT  = 8'h74;  // 't'
  localparam logic [7:0] ChLowU  = 8'h75;  // 'u'
  localparam logic [7:0] ChLowX  = 8'h78;  // 'x'
  localparam logic [7:0] ChCase  = 8'h20;  // ' ', case bit

  // Name indexes
  localparam logic [2:0] NameAmp  = 3'd0;
  localparam logic [2:0] NameApos = 3'd1;
  localparam logic [2:0] NameGt   = 3'd2;
  localparam logic [2:0] NameLt   = 3'd3;
  localparam logic [2:0] NameQuot = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       from_reference;
    logic       last_of_run;
  } out_item_t;

  // One run of result bytes caused by a single input
  typedef struct packed {
    logic [MaxResults-1:0][7:0] bytes;
    logic [MaxResults-1:0]      refs;
    logic [CountW-1:0]          count;
  } run_t;

  // Spelling of each name, position 0 is the first letter after '&'
  function automatic logic [7:0] name_text_at(input logic [2:0] idx,
                                              input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case (idx)
      NameAmp: begin
        case (pos)
          3'd0: ch = ChLowA;
          3'd1: ch = ChLowM;
          3'd2: ch = ChLowP;
          3'd3: ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      NameApos: begin
        case (pos)
          3'd0: ch = ChLowA;
          3'd1: ch = ChLowP;
          3'd2: ch = ChLowO;
          3'd3: ch = ChLowS;
          3'd4: ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      NameGt: begin
        case (pos)
          3'd0: ch = ChLowG;
          3'd1: ch = ChLowT;
          3'd2: ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      NameLt: begin
        case (pos)
          3'd0: ch = ChLowL;
          3'd1: ch = ChLowT;
          3'd2: ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      NameQuot: begin
        case (pos)
          3'd0: ch = ChLowQ;
          3'd1: ch = ChLowU;
          3'd2: ch = ChLowO;
          3'd3: ch = ChLowT;
          3'd4: ch = ChSemi;
          default: ch = 8'h00;
        endcase
      end
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Character that each name stands for
  function automatic logic [7:0] name_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      NameAmp:  ch = ChAmp;
      NameApos: ch = ChApos;
      NameGt:   ch = ChGt;
      NameLt:   ch = ChLt;
      NameQuot: ch = ChQuot;
      default:  ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> hdl/char_reference_decoder_unit.sv
// ----------------------------------------------------------------------------
// char_reference_decoder_unit
// Character reference decoder: passes text bytes, decodes named and numeric
// references to bytes or UTF-8, replays cancelled references verbatim.
// ----------------------------------------------------------------------------
// The first result of an input passes through the input register, then
// the result register.
// Throughput: one input per cycle while no input yields more than one byte
// and out_stall is low; a longer run holds the result register until sent.
// Reset (rst, synchronous): no reference open, no pending input or results.
`default_nettype none

module char_reference_decoder_unit
  import crd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  in_item_t item_q;
  logic     item_valid;
  logic     free;
  logic     advance;
  logic     load;
  run_t     run;

  assign advance  = item_valid && free;
  assign load     = advance && (run.count != '0);
  assign in_stall = item_valid && !free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_q <= in_item;
    end
  end

  crd_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (item_q),
    .run  (run)
  );

  crd_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .run       (run),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> hdl/crd_parser.sv
// ----------------------------------------------------------------------------
// crd_parser
// Reference parse state and held bytes; turns one registered input into the
// run of result bytes it causes and updates the state on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module crd_parser
  import crd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire in_item_t item,
  output run_t          run
);

  // Parse modes
  localparam logic [3:0] ModeIdle  = 4'd0;
  localparam logic [3:0] ModeAmp   = 4'd1;
  localparam logic [3:0] ModeA     = 4'd2;
  localparam logic [3:0] ModeName0 = 4'd3;
  localparam logic [3:0] ModeName1 = 4'd4;
  localparam logic [3:0] ModeName2 = 4'd5;
  localparam logic [3:0] ModeName3 = 4'd6;
  localparam logic [3:0] ModeName4 = 4'd7;
  localparam logic [3:0] ModeHash  = 4'd8;
  localparam logic [3:0] ModeDec   = 4'd9;
  localparam logic [3:0] ModeHex   = 4'd10;

  logic [3:0]       mode, mode_next;
  logic [31:0]      cv, cv_next;
  logic [RcW-1:0]   rc, rc_next;
  logic [DcW-1:0]   dc, dc_next;
  logic [7:0]       store [StoreDepth];

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic             taken;
  logic             do_replay;
  logic [2:0]       tail_n;
  logic [3:0][7:0]  tail_b;
  logic             tail_ref;

  logic [7:0]       b;
  logic [7:0]       lower;
  logic             is_dig;
  logic             is_hexl;
  logic [3:0]       dv;
  logic [2:0]       name_idx;
  logic [RcW-1:0]   pos;
  logic [31:0]      cv_mul;

  assign b        = item.in_byte;
  assign lower    = b | ChCase;
  assign is_dig   = (b - ChZero) <= 8'd9;
  assign is_hexl  = (lower - ChLowA) <= 8'd5;
  assign dv       = is_dig ? b[3:0] : (lower[3:0] + 4'd9);
  assign name_idx = 3'(mode - ModeName0);
  assign pos      = rc - 1'b1;
  assign cv_mul   = (mode == ModeHex) ? {cv[27:0], 4'b0000}
                                      : ({cv[28:0], 3'b000} + {cv[30:0], 1'b0});

  // UTF-8 bytes of the current code point
  logic [2:0]      u_n;
  logic [3:0][7:0] u_b;

  always_comb begin
    u_b = '0;
    if (cv < 32'h80) begin
      u_n    = 3'd1;
      u_b[0] = cv[7:0];
    end else if (cv < 32'h800) begin
      u_n    = 3'd2;
      u_b[0] = {3'b110, cv[10:6]};
      u_b[1] = {2'b10, cv[5:0]};
    end else if (cv < 32'h10000) begin
      u_n    = 3'd3;
      u_b[0] = {4'b1110, cv[15:12]};
      u_b[1] = {2'b10, cv[11:6]};
      u_b[2] = {2'b10, cv[5:0]};
    end else begin
      u_n    = 3'd4;
      u_b[0] = 8'hF0 | cv[25:18];
      u_b[1] = {2'b10, cv[17:12]};
      u_b[2] = {2'b10, cv[11:6]};
      u_b[3] = {2'b10, cv[5:0]};
    end
  end

  // Next state and the tail of the run
  always_comb begin
    mode_next = mode;
    cv_next   = cv;
    rc_next   = rc;
    dc_next   = dc;
    wr_en     = 1'b0;
    wr_addr   = '0;
    taken     = 1'b0;
    do_replay = 1'b0;
    tail_n    = '0;
    tail_b    = '0;
    tail_ref  = 1'b0;

    if (item.end_of_text) begin
      do_replay = 1'b1;
      mode_next = ModeIdle;
      cv_next   = '0;
      rc_next   = '0;
      dc_next   = '0;
    end else begin
      if (mode != ModeIdle) begin
        unique case (mode)
          ModeAmp: begin
            taken = 1'b1;
            if (b == ChLowA)      mode_next = ModeA;
            else if (b == ChLowG) mode_next = ModeName2;
            else if (b == ChLowL) mode_next = ModeName3;
            else if (b == ChLowQ) mode_next = ModeName4;
            else if (b == ChHash) mode_next = ModeHash;
            else                  taken = 1'b0;
          end
          ModeA: begin
            taken = 1'b1;
            if (b == ChLowM)      mode_next = ModeName0;
            else if (b == ChLowP) mode_next = ModeName1;
            else                  taken = 1'b0;
          end
          ModeName0, ModeName1, ModeName2, ModeName3, ModeName4: begin
            if (rc != '0 && pos < RcW'(6) && b == name_text_at(name_idx, pos[2:0])) begin
              taken = 1'b1;
              if (b == ChSemi) begin
                tail_n    = 3'd1;
                tail_b[0] = name_char(name_idx);
                tail_ref  = 1'b1;
                mode_next = ModeIdle;
                cv_next   = '0;
                rc_next   = '0;
                dc_next   = '0;
              end
            end
          end
          ModeHash: begin
            taken = 1'b1;
            if (b == ChLowX) begin
              mode_next = ModeHex;
            end else if (is_dig) begin
              mode_next = ModeDec;
              cv_next   = {28'd0, b[3:0]};
              dc_next   = DcW'(1);
            end else begin
              taken = 1'b0;
            end
          end
          ModeDec, ModeHex: begin
            if (b == ChSemi) begin
              if (dc != '0) begin
                taken     = 1'b1;
                tail_n    = u_n;
                tail_b    = u_b;
                tail_ref  = 1'b1;
                mode_next = ModeIdle;
                cv_next   = '0;
                rc_next   = '0;
                dc_next   = '0;
              end
            end else if ((is_dig || (mode == ModeHex && is_hexl)) &&
                         dc < DcW'(MaxDigits)) begin
              taken   = 1'b1;
              cv_next = cv_mul + {28'd0, dv};
              dc_next = dc + 1'b1;
            end
          end
          default: taken = 1'b0;
        endcase

        // Held bytes of an accepted byte that did not close the reference
        if (taken && mode_next != ModeIdle && rc_next < RcW'(StoreDepth)) begin
          wr_en   = 1'b1;
          wr_addr = rc_next[AddrW-1:0];
          rc_next = rc_next + 1'b1;
        end

        // Cancel: replay held bytes, then handle the byte again
        if (!taken) begin
          do_replay = 1'b1;
          mode_next = ModeIdle;
          cv_next   = '0;
          rc_next   = '0;
          dc_next   = '0;
        end
      end

      if (!taken) begin
        if (b == ChAmp) begin
          mode_next = ModeAmp;
          cv_next   = '0;
          dc_next   = '0;
          wr_en     = 1'b1;
          wr_addr   = '0;
          rc_next   = RcW'(1);
        end else begin
          tail_n    = 3'd1;
          tail_b[0] = b;
        end
      end
    end
  end

  // Assemble the run: replayed bytes first, then the tail
  logic [RcW-1:0]    base;
  logic [CountW-1:0] jj;

  assign base = do_replay ? rc : '0;

  always_comb begin
    run.bytes = '0;
    run.refs  = '0;
    jj        = '0;
    for (int i = 0; i < MaxResults; i++) begin
      jj = CountW'(i) - CountW'(base);
      if (CountW'(i) >= CountW'(base) && jj < CountW'(tail_n)) begin
        run.bytes[i] = tail_b[jj[1:0]];
        run.refs[i]  = tail_ref;
      end
    end
    for (int i = 0; i < StoreDepth; i++) begin
      if (do_replay && RcW'(i) < rc) begin
        run.bytes[i] = store[i];
        run.refs[i]  = 1'b0;
      end
    end
    run.count = CountW'(base) + CountW'(tail_n);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeIdle;
      cv   <= '0;
      rc   <= '0;
      dc   <= '0;
    end else if (step) begin
      mode <= mode_next;
      cv   <= cv_next;
      rc   <= rc_next;
      dc   <= dc_next;
    end
  end

  // Held bytes, no reset: only written entries are read
  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      store[wr_addr] <= b;
    end
  end

  a_rc_range: assert property (@(posedge clk) disable iff (rst)
    rc <= RcW'(StoreDepth))
    else $error("held byte count beyond store depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == ModeIdle) |-> (rc == '0 && dc == '0 && cv == '0))
    else $error("idle with reference state left over");

  a_open_held: assert property (@(posedge clk) disable iff (rst)
    (mode != ModeIdle) |-> (rc != '0))
    else $error("open reference with no held bytes");

endmodule

`default_nettype wire

>>> hdl/crd_emitter.sv
// ----------------------------------------------------------------------------
// crd_emitter
// Result register: holds one run of bytes and sends them one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module crd_emitter
  import crd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      load,
  input  wire run_t      run,
  output logic           free,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic [MaxResults-1:0][7:0] bytes;
  logic [MaxResults-1:0]      refs;
  logic [CountW-1:0]          count;
  logic                       xfer;

  assign out_valid = (count != '0);
  assign xfer      = out_valid && !out_stall;
  // Free when empty or once the last byte of the current run leaves
  assign free      = (count == '0) || (count == CountW'(1) && !out_stall);

  assign out_item.out_byte       = bytes[0];
  assign out_item.from_reference = refs[0];
  assign out_item.last_of_run    = (count == CountW'(1));

  // Run count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run.count;
    end else if (xfer) begin
      count <= count - 1'b1;
    end
  end

  // Byte shift register
  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= run.bytes;
      refs  <= run.refs;
    end else if (xfer) begin
      bytes <= bytes >> 8;
      refs  <= refs >> 1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(MaxResults))
    else $error("run count beyond maximum");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> free)
    else $error("run loaded over unsent bytes");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (xfer && count > CountW'(1)) |=> (count == $past(count) - 1'b1))
    else $error("run count did not step down after transfer");

endmodule

`default_nettype wire
